FILE: rtl/four_level_page_walker_top_macros.svh
// Assertion macros for the page walker step module.
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define FLPW_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("page walker check failed");

// Check that cond holds in the cycle after trig.
`define FLPW_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("page walker check failed");

`endif

FILE: rtl/flpw_pkg.sv
// Types, constants and address helper for the four-level page walker.
`timescale 1ns / 1ps

package flpw_pkg;

    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int ENTRY_W  = 64;
    localparam int IDX_W    = 9;
    localparam int PAGE_SH  = 12;
    localparam int ENTRY_SH = 3;

    localparam int SHIFT_L0 = 39;
    localparam int SHIFT_L1 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L3 = 12;

    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 120;

    localparam logic [1:0] LEVEL_TOP  = 2'd0;
    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_RW      = 1;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } walk_state_t;

    typedef struct packed {
        logic               op;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    root_base;
        logic               want_write;
        logic [ENTRY_W-1:0] mem_data;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [PA_W-1:0]    mem_addr;
        logic               hit;
        logic [ENTRY_W-1:0] phys_page;
    } result_t;

    function automatic logic [PA_W-1:0] entry_addr(
        input logic [PA_W-1:0] base,
        input logic [VA_W-1:0] va,
        input logic [1:0]      lvl
    );
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0: begin
                idx = IDX_W'(va >> SHIFT_L0);
            end
            2'd1: begin
                idx = IDX_W'(va >> SHIFT_L1);
            end
            2'd2: begin
                idx = IDX_W'(va >> SHIFT_L2);
            end
            default: begin
                idx = IDX_W'(va >> SHIFT_L3);
            end
        endcase
        return {base[PA_W-1:PAGE_SH], idx, {ENTRY_SH{1'b0}}};
    endfunction

endpackage

FILE: rtl/flpw_in_reg.sv
// Input register stage: capture one word from the input channel.
`timescale 1ns / 1ps

module flpw_in_reg
    import flpw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  advance,
    output logic                  item_valid,
    output in_item_t              item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op         <= s_tuser[0];
            item_reg.virt_addr  <= s_tdata[47:0];
            item_reg.root_base  <= s_tdata[99:48];
            item_reg.want_write <= s_tdata[100];
            item_reg.mem_data   <= s_tdata[164:101];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/flpw_walk.sv
// Walk state and per-word step logic of the page walker.
`timescale 1ns / 1ps

`include "four_level_page_walker_top_macros.svh"

module flpw_walk
    import flpw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     item_valid,
    input  in_item_t item,
    input  logic     advance,
    output logic     res_valid,
    output result_t  res
);

    walk_state_t     state_reg;
    walk_state_t     state_next;
    logic [1:0]      level_reg;
    logic [1:0]      level_next;
    logic [VA_W-1:0] virt_reg;
    logic [VA_W-1:0] virt_next;
    logic            write_reg;
    logic            write_next;
    logic            perm_ok;

    assign perm_ok = !(write_reg && !item.mem_data[BIT_RW]);

    always_comb begin
        state_next    = state_reg;
        level_next    = level_reg;
        virt_next     = virt_reg;
        write_next    = write_reg;
        res_valid     = 1'b0;
        res.kind      = KIND_READ;
        res.mem_addr  = '0;
        res.hit       = 1'b0;
        res.phys_page = '0;
        if (item_valid) begin
            if (item.op == OP_REQUEST) begin
                if (state_reg == ST_IDLE) begin
                    virt_next    = item.virt_addr;
                    write_next   = item.want_write;
                    level_next   = LEVEL_TOP;
                    state_next   = ST_WALK;
                    res_valid    = 1'b1;
                    res.mem_addr = entry_addr(item.root_base, item.virt_addr, LEVEL_TOP);
                end
            end else if (state_reg == ST_WALK) begin
                res_valid = 1'b1;
                if (!item.mem_data[BIT_PRESENT]) begin
                    state_next = ST_IDLE;
                    level_next = LEVEL_TOP;
                    res.kind   = KIND_DONE;
                end else if (level_reg != LEVEL_LEAF) begin
                    level_next   = level_reg + 2'd1;
                    res.mem_addr = entry_addr(item.mem_data[PA_W-1:0], virt_reg,
                                              level_reg + 2'd1);
                end else begin
                    state_next = ST_IDLE;
                    level_next = LEVEL_TOP;
                    res.kind   = KIND_DONE;
                    res.hit    = perm_ok;
                    if (perm_ok) begin
                        res.phys_page = {item.mem_data[ENTRY_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            level_reg <= LEVEL_TOP;
            virt_reg  <= '0;
            write_reg <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
            level_reg <= level_next;
            virt_reg  <= virt_next;
            write_reg <= write_next;
        end
    end

    `FLPW_ASSERT_SAME(a_done_only_walking, aclk, aresetn,
        res_valid && res.kind == KIND_DONE, state_reg == ST_WALK)
    `FLPW_ASSERT_SAME(a_hit_only_at_leaf, aclk, aresetn,
        res_valid && res.hit, level_reg == LEVEL_LEAF && res.kind == KIND_DONE)
    `FLPW_ASSERT_SAME(a_level_implies_walk, aclk, aresetn,
        level_reg != LEVEL_TOP, state_reg == ST_WALK)
    `FLPW_ASSERT_NEXT(a_read_keeps_walking, aclk, aresetn,
        advance && res_valid && res.kind == KIND_READ, state_reg == ST_WALK)

endmodule

FILE: rtl/flpw_out_reg.sv
// Result register stage: hold one result word for the output channel.
`timescale 1ns / 1ps

module flpw_out_reg
    import flpw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   res_valid,
    input  result_t                res,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]             m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {3'b000, res_reg.phys_page, res_reg.hit, res_reg.mem_addr};

endmodule

FILE: rtl/four_level_page_walker_top.sv
// Top level of the four-level page walker.
//
// The walker takes one word per cycle on the input channel: a translate request
// (tuser 0) or a table entry returned by memory (tuser 1), and answers each word
// that counts with one result word, held first in the input register and then,
// after the step logic between them, in the result register. Results are
// entry read requests (tuser 0, mem_addr) or a finished translation (tuser 1, hit,
// phys_page). A request while a walk is running and data while idle give no
// result. Input is taken every cycle as long as the result register is free or
// being drained; there is no start-up sweep after reset.
`timescale 1ns / 1ps

module four_level_page_walker_top
    import flpw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // virt_addr[47:0], root_base[99:48], want_write[100], mem_data[164:101], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mem_addr[51:0], hit[52], phys_page[116:53], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic [0:0]             m_tuser
);

    logic     item_valid;
    in_item_t item;
    logic     res_valid;
    result_t  res;
    logic     out_free;
    logic     advance;

    assign advance = item_valid && out_free;

    flpw_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    flpw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    flpw_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
